// ===== rtl/core/nodata_region_shrink_expand_core_assert.svh =====
// Assertion macros used by the core module.
`ifndef NODATA_REGION_SHRINK_EXPAND_CORE_ASSERT_SVH
`define NODATA_REGION_SHRINK_EXPAND_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define NRSE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define NRSE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/nrse_pkg.sv =====
package nrse_pkg;

	// Cell value width of the input field
	localparam int VALUE_BITS = 16;
	localparam int RESULT_BITS = 24;

	// Saturation bounds of the signed Q.8 result
	localparam int Q_MAX = 8388607;
	localparam int Q_MIN = -8388608;

	// Configuration port
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_EXPAND_MODE = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CIRCLE_KERNEL = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FILL_METHOD = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 3'd5;

	// Item operations
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// Fill methods
	localparam logic [1:0] FILL_MIN = 2'd0;
	localparam logic [1:0] FILL_MAX = 2'd1;
	localparam logic [1:0] FILL_MEAN = 2'd2;

	typedef struct packed {
		logic operation;
		logic signed [VALUE_BITS-1:0] pixel_value;
		logic pixel_nodata;
	} nrse_item_t;

	typedef struct packed {
		logic signed [RESULT_BITS-1:0] result_value;
		logic result_nodata;
		logic frame_end;
	} nrse_result_t;

endpackage

// ===== rtl/core/nrse_line_store.sv =====
module nrse_line_store #(
	parameter int DEPTH = 10240,
	parameter int WIDTH = 17
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/nrse_divider.sv =====
module nrse_divider #(
	parameter int NW = 31,
	parameter int DW = 7
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [NW-1:0] num,
	input logic [DW-1:0] den,
	output logic done,
	output logic [NW-1:0] quo
);

	localparam int KW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [KW-1:0] cnt_q;
	logic done_q;
	logic [DW:0] shifted;
	logic fits;

	// Bring down the next numerator bit and try the subtract
	always_comb begin
		shifted = {rem_q, quo_q[NW-1]};
		fits = shifted >= {1'b0, den_q};
	end

	// Restoring division, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= KW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == KW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= DW'(shifted - {1'b0, den_q});
			end else begin
				rem_q <= shifted[DW-1:0];
			end
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

// ===== rtl/core/nodata_region_shrink_expand_core.sv =====
// Shrinks or expands valid regions of a raster streamed in row order. An item that
// releases no result passes from idle through the check state and back. An item that
// releases a result also walks its window, reading one line store cell per cycle
// from the single read port, then evaluates; a mean fill adds one restoring divide
// of one quotient bit per cycle before the result is loaded.
// Results sit in an output register, so a stalled result holds only the next item.
// The line store holds 2*MAX_RADIUS+2 rows of MAX_WIDTH cells.
`include "nodata_region_shrink_expand_core_assert.svh"

module nodata_region_shrink_expand_core #(
	parameter int MAX_RADIUS = 4,
	parameter int MAX_WIDTH = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [nrse_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [nrse_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input logic item_valid,
	output logic item_stall,
	input nrse_pkg::nrse_item_t item,
	output logic result_valid,
	input logic result_stall,
	output nrse_pkg::nrse_result_t result
);

	import nrse_pkg::*;

	localparam int LINE_ROWS = 2 * MAX_RADIUS + 2;
	localparam int DEPTH = LINE_ROWS * MAX_WIDTH;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;
	localparam int RMW = $clog2(LINE_ROWS);
	localparam int RW = $clog2(MAX_RADIUS + 1);
	localparam int OW = RW + 1;
	localparam int SQW = 2 * RW + 1;
	localparam int CNTW = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1));
	localparam int SUMW = VALUE_BITS + CNTW;
	localparam int NW = SUMW + 8;
	localparam int QW = VALUE_BITS + 9;
	localparam int EW = (QW > RESULT_BITS) ? QW : RESULT_BITS;
	localparam int MW = VALUE_BITS + 1;

	localparam logic signed [EW-1:0] QMAX_E = EW'(Q_MAX);
	localparam logic signed [EW-1:0] QMIN_E = EW'(Q_MIN);
	localparam logic signed [RMW+1:0] LR_S = (RMW + 2)'(LINE_ROWS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_WALK = 3'd2;
	localparam logic [2:0] ST_LAST = 3'd3;
	localparam logic [2:0] ST_EVAL = 3'd4;
	localparam logic [2:0] ST_DIV = 3'd5;
	localparam logic [2:0] ST_OUT = 3'd6;

	// Configuration registers
	logic expand_q, circle_q;
	logic [2:0] radius_q;
	logic [1:0] fill_q;
	logic [10:0] gwidth_q;
	logic [15:0] gheight_q;

	// Position counters
	logic [CW-1:0] in_col_q, out_col_q;
	logic [15:0] in_row_q, out_row_q;
	logic [RMW-1:0] in_rmod_q, out_rmod_q;
	logic in_done_q;

	logic [2:0] state_q;
	logic signed [OW-1:0] dx_q, dy_q;

	// Window accumulators
	logic rd_s1, cen_s1;
	logic signed [VALUE_BITS-1:0] cen_val_q, mn_q, mx_q;
	logic cen_nd_q, any_nd_q;
	logic [CNTW-1:0] cnt_q;
	logic signed [SUMW-1:0] sum_q;
	logic mean_neg_q;

	// Output register
	logic res_valid_q;
	nrse_result_t res_q;

	logic [WW-1:0] w_eff;
	logic [15:0] h_eff;
	logic [RW-1:0] r_eff;
	logic accept, mem_we, out_load;
	logic [AW-1:0] waddr, raddr;
	logic [MW-1:0] rdata;
	logic [16:0] ry, hm1;
	logic [CW:0] cx, wm1;
	logic ready;
	logic signed [17:0] ny;
	logic signed [CW+1:0] nx;
	logic signed [RMW+1:0] rm;
	logic [RW-1:0] adx, ady;
	logic [SQW-1:0] sq, rsq;
	logic in_kernel, rd_en, is_center;
	logic signed [OW-1:0] r_s;
	logic ev_nd, ev_div;
	logic signed [EW-1:0] ev_val, sat_val, div_val;
	logic [SUMW-1:0] sum_abs;
	logic [NW-1:0] div_num, div_quo;
	logic div_done;
	logic out_last_col, out_last_row;

	// Clamp the geometry registers to their usable ranges
	always_comb begin
		if (gwidth_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(gwidth_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(gwidth_q);
		end
		h_eff = (gheight_q == '0) ? 16'd1 : gheight_q;
		if (radius_q == '0) begin
			r_eff = RW'(1);
		end else if (32'(radius_q) > 32'(MAX_RADIUS)) begin
			r_eff = RW'(MAX_RADIUS);
		end else begin
			r_eff = RW'(radius_q);
		end
	end

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expand_q <= 1'b1;
			circle_q <= 1'b1;
			radius_q <= 3'd1;
			fill_q <= FILL_MIN;
			gwidth_q <= 11'd1024;
			gheight_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EXPAND_MODE: expand_q <= cfg_data[0];
				REG_CIRCLE_KERNEL: circle_q <= cfg_data[0];
				REG_RADIUS: radius_q <= cfg_data[2:0];
				REG_FILL_METHOD: fill_q <= cfg_data[1:0];
				REG_GRID_WIDTH: gwidth_q <= cfg_data[10:0];
				REG_GRID_HEIGHT: gheight_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Input handshake and pixel write
	assign item_stall = (state_q != ST_IDLE);
	assign accept = item_valid && !item_stall;
	assign mem_we = accept && (item.operation == OP_PIXEL) && !in_done_q;
	assign waddr = AW'(32'(in_rmod_q) * MAX_WIDTH) + AW'(in_col_q);

	// Check whether the next pending result has its whole window
	always_comb begin
		hm1 = {1'b0, h_eff} - 17'd1;
		ry = {1'b0, out_row_q} + 17'(r_eff);
		if (ry > hm1) begin
			ry = hm1;
		end
		wm1 = w_eff - WW'(1);
		cx = {1'b0, out_col_q} + (CW + 1)'(r_eff);
		if (cx > wm1) begin
			cx = wm1;
		end
		ready = in_done_q || ({1'b0, in_row_q} > ry)
			|| (({1'b0, in_row_q} == ry) && ({1'b0, in_col_q} > cx));
	end

	// Window cell address and kernel membership
	always_comb begin
		r_s = $signed({1'b0, r_eff});
		ny = $signed({2'b0, out_row_q}) + 18'(dy_q);
		nx = $signed({2'b0, out_col_q}) + (CW + 2)'(dx_q);
		rm = $signed({2'b0, out_rmod_q}) + (RMW + 2)'(dy_q);
		if (rm < 0) begin
			rm = rm + LR_S;
		end else if (rm >= LR_S) begin
			rm = rm - LR_S;
		end
		adx = (dx_q < 0) ? RW'(-dx_q) : RW'(dx_q);
		ady = (dy_q < 0) ? RW'(-dy_q) : RW'(dy_q);
		sq = SQW'(adx * adx) + SQW'(ady * ady);
		rsq = SQW'(r_eff * r_eff);
		is_center = (dx_q == '0) && (dy_q == '0);
		in_kernel = !(circle_q && (sq > rsq)) && (ny >= 0)
			&& (ny < $signed({2'b0, h_eff})) && (nx >= 0)
			&& (nx < $signed({1'b0, w_eff}));
		rd_en = (state_q == ST_WALK) && in_kernel;
		raddr = AW'(32'(rm[RMW-1:0]) * MAX_WIDTH) + AW'(nx[CW-1:0]);
	end

	nrse_line_store #(
		.DEPTH(DEPTH),
		.WIDTH(MW)
	) u_store (
		.clk(clk),
		.we(mem_we),
		.waddr(waddr),
		.wdata({item.pixel_nodata, item.pixel_value}),
		.re(rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Decide the result once the window is gathered
	always_comb begin
		ev_nd = cen_nd_q;
		ev_div = 1'b0;
		ev_val = EW'($signed({cen_val_q, 8'b0}));
		if (!expand_q) begin
			ev_nd = cen_nd_q || any_nd_q;
		end else if (cen_nd_q && (cnt_q != '0)) begin
			case (fill_q)
				FILL_MIN: begin
					ev_nd = 1'b0;
					ev_val = EW'($signed({mn_q, 8'b0}));
				end
				FILL_MAX: begin
					ev_nd = 1'b0;
					ev_val = EW'($signed({mx_q, 8'b0}));
				end
				FILL_MEAN: begin
					ev_nd = 1'b0;
					ev_div = 1'b1;
				end
				default: ev_nd = 1'b1;
			endcase
		end
		sum_abs = (sum_q < 0) ? SUMW'(-sum_q) : SUMW'(sum_q);
		div_num = NW'({sum_abs, 8'b0}) + NW'(cnt_q >> 1);
	end

	nrse_divider #(
		.NW(NW),
		.DW(CNTW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start((state_q == ST_EVAL) && ev_div),
		.num(div_num),
		.den(cnt_q),
		.done(div_done),
		.quo(div_quo)
	);

	assign div_val = mean_neg_q ? -EW'(div_quo) : EW'(div_quo);

	// Saturate to the Q.8 result range
	always_comb begin
		if (ev_div) begin
			sat_val = div_val;
		end else begin
			sat_val = ev_val;
		end
		if (sat_val > QMAX_E) begin
			sat_val = QMAX_E;
		end else if (sat_val < QMIN_E) begin
			sat_val = QMIN_E;
		end
	end

	assign out_load = (state_q == ST_OUT) && (!res_valid_q || !result_stall);
	assign out_last_col = ({1'b0, out_col_q} + 1'b1) >= w_eff;
	assign out_last_row = ({1'b0, out_row_q} + 17'd1) >= {1'b0, h_eff};

	// Sequencer, counters and window walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			in_col_q <= '0;
			in_row_q <= '0;
			in_rmod_q <= '0;
			in_done_q <= 1'b0;
			out_col_q <= '0;
			out_row_q <= '0;
			out_rmod_q <= '0;
			dx_q <= '0;
			dy_q <= '0;
			rd_s1 <= 1'b0;
			cen_s1 <= 1'b0;
		end else begin
			rd_s1 <= rd_en;
			cen_s1 <= is_center;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CHECK;
						if (mem_we) begin
							if (({1'b0, in_col_q} + 1'b1) >= w_eff) begin
								in_col_q <= '0;
								if (({1'b0, in_row_q} + 17'd1) >= {1'b0, h_eff}) begin
									in_done_q <= 1'b1;
								end else begin
									in_row_q <= in_row_q + 16'd1;
									in_rmod_q <= (32'(in_rmod_q) == LINE_ROWS - 1)
										? '0 : in_rmod_q + 1'b1;
								end
							end else begin
								in_col_q <= in_col_q + 1'b1;
							end
						end
					end
				end
				ST_CHECK: begin
					if (ready) begin
						state_q <= ST_WALK;
						dx_q <= -r_s;
						dy_q <= -r_s;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (dx_q == r_s) begin
						dx_q <= -r_s;
						if (dy_q == r_s) begin
							state_q <= ST_LAST;
						end else begin
							dy_q <= dy_q + 1'b1;
						end
					end else begin
						dx_q <= dx_q + 1'b1;
					end
				end
				ST_LAST: state_q <= ST_EVAL;
				ST_EVAL: state_q <= ev_div ? ST_DIV : ST_OUT;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
						if (out_last_col) begin
							out_col_q <= '0;
							if (out_last_row) begin
								out_row_q <= '0;
								out_rmod_q <= '0;
								in_row_q <= '0;
								in_col_q <= '0;
								in_rmod_q <= '0;
								in_done_q <= 1'b0;
							end else begin
								out_row_q <= out_row_q + 16'd1;
								out_rmod_q <= (32'(out_rmod_q) == LINE_ROWS - 1)
									? '0 : out_rmod_q + 1'b1;
							end
						end else begin
							out_col_q <= out_col_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Fold each returned cell into the window statistics
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			cnt_q <= '0;
			sum_q <= '0;
			any_nd_q <= 1'b0;
			cen_nd_q <= 1'b0;
			cen_val_q <= '0;
		end else if (rd_s1) begin
			if (cen_s1) begin
				cen_nd_q <= rdata[MW-1];
				cen_val_q <= $signed(rdata[VALUE_BITS-1:0]);
			end else if (rdata[MW-1]) begin
				any_nd_q <= 1'b1;
			end else begin
				if ((cnt_q == '0) || ($signed(rdata[VALUE_BITS-1:0]) < mn_q)) begin
					mn_q <= $signed(rdata[VALUE_BITS-1:0]);
				end
				if ((cnt_q == '0) || ($signed(rdata[VALUE_BITS-1:0]) > mx_q)) begin
					mx_q <= $signed(rdata[VALUE_BITS-1:0]);
				end
				sum_q <= sum_q + SUMW'($signed(rdata[VALUE_BITS-1:0]));
				cnt_q <= cnt_q + 1'b1;
			end
		end
		if (state_q == ST_EVAL) begin
			mean_neg_q <= (sum_q < 0);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q.result_nodata <= ev_nd;
			res_q.result_value <= ev_nd ? '0 : RESULT_BITS'(sat_val);
			res_q.frame_end <= out_last_col && out_last_row;
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

	`NRSE_ASSERT_NEXT(a_accept_checks, accept, state_q == ST_CHECK)
	`NRSE_ASSERT_NOW(a_div_done_in_div, div_done, state_q == ST_DIV)
	`NRSE_ASSERT_NOW(a_load_free, out_load, !res_valid_q || !result_stall)
	`NRSE_ASSERT_NOW(a_write_idle, mem_we, state_q == ST_IDLE && !rd_en)

endmodule
